/* hw/rtl/lssc_pkg.sv */
// lssc_pkg: shared types, constants and microcode ROM for the line sensor
// scan centroid block. No dependencies; used by line_sensor_scan_centroid.

package lssc_pkg;

  localparam int unsigned PcW = 2;
  typedef logic [PcW-1:0] pc_t;

  localparam pc_t PC_FETCH   = 2'd0;
  localparam pc_t PC_DIVINIT = 2'd1;
  localparam pc_t PC_DIVSTEP = 2'd2;
  localparam pc_t PC_FINISH  = 2'd3;

  // config register indexes
  localparam logic [1:0] REG_REVERSE_ORDER = 2'd0;
  localparam logic [1:0] REG_BLACK_IS_HIGH = 2'd1;
  localparam logic [1:0] REG_SETTLE_TICKS  = 2'd2;

  localparam logic [15:0] SETTLE_RESET  = 16'd70;
  localparam logic [3:0]  DIV_LAST_ITER = 4'd14;
  localparam logic [2:0]  LAST_CHANNEL  = 3'd7;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_DIV_PENDING,
    COND_ITER_MORE,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic  wait_in;   // step takes an input word
    logic  div_init;
    logic  div_step;
    logic  emit;      // load result register from divider
    logic  hold;      // stay on this step when no jump
    cond_t cond;
    pc_t   target;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode_rom(input pc_t pc);
    ctrl_word_t cw;
    cw = '0;
    case (pc)
      PC_FETCH: begin
        cw.wait_in = 1'b1;
        cw.hold    = 1'b1;
        cw.cond    = COND_DIV_PENDING;
        cw.target  = PC_DIVINIT;
      end
      PC_DIVINIT: begin
        cw.div_init = 1'b1;
        cw.cond     = COND_NONE;
        cw.target   = PC_DIVSTEP;
      end
      PC_DIVSTEP: begin
        cw.div_step = 1'b1;
        cw.cond     = COND_ITER_MORE;
        cw.target   = PC_DIVSTEP;
      end
      PC_FINISH: begin
        cw.emit   = 1'b1;
        cw.hold   = 1'b1;
        cw.cond   = COND_OUT_FREE;
        cw.target = PC_FETCH;
      end
      default: begin
        cw.wait_in = 1'b1;
        cw.hold    = 1'b1;
        cw.cond    = COND_DIV_PENDING;
        cw.target  = PC_DIVINIT;
      end
    endcase
    return cw;
  endfunction

  function automatic logic signed [14:0] bit_weight(input logic [2:0] b);
    logic signed [14:0] w;
    case (b)
      3'd0:    w = -15'sd3500;
      3'd1:    w = -15'sd2500;
      3'd2:    w = -15'sd1500;
      3'd3:    w = -15'sd500;
      3'd4:    w = 15'sd500;
      3'd5:    w = 15'sd1500;
      3'd6:    w = 15'sd2500;
      default: w = 15'sd3500;
    endcase
    return w;
  endfunction

endpackage

/* hw/rtl/line_sensor_scan_centroid.sv */
// line_sensor_scan_centroid: top level, microcoded scan sequencer with
// weighted centroid and a small restoring divider. Depends on lssc_pkg.
//
// Usage:
//  - Input channel: one word per timer tick (in_start_req, in_sensor_level),
//    handshake in_valid / in_stall. Every input word yields exactly one
//    output word on the out_ channel (out_valid / out_stall).
//  - A start request while idle begins a scan of mux channels 0..7; each
//    channel waits settle_ticks words before its sample is taken.
//  - Ordinary ticks: result registered on accept, presented in the next cycle; one word per
//    cycle sustained while the receiver keeps up.
//  - The tick that finishes a scan with a black bit runs the divider:
//    fetch, init, 15 divide steps, then load; the steps come from the
//    one-bit-per-cycle divider. A finishing tick with no black bit is
//    registered like an ordinary tick.
//  - While the receiver stalls, the result word holds and no new input
//    word is taken until the output register drains.
//  - Reset (rst_n low, synchronous) returns to idle, channel 0, registers
//    reverse_order=0, black_is_high=1, settle_ticks=70, no output pending.
//  - Config writes (cfg_we, cfg_index, cfg_wdata) apply from the next tick.

module line_sensor_scan_centroid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_start_req,
  input  logic               in_sensor_level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_mux_select,
  output logic               out_busy_res,
  output logic               out_done_res,
  output logic [7:0]         out_level_map,
  output logic [7:0]         out_dark_map,
  output logic [3:0]         out_dark_total,
  output logic               out_track_found,
  output logic signed [12:0] out_line_error
);

  // config
  logic        reverse_order_r;
  logic        black_is_high_r;
  logic [15:0] settle_ticks_r;

  // sequencer
  lssc_pkg::pc_t        pc_r, pc_nxt;
  lssc_pkg::ctrl_word_t cw;
  logic                 taken;

  // scan state
  logic               scanning_r, scanning_nxt;
  logic [2:0]         chan_r, chan_nxt;
  logic [15:0]        settle_r, settle_nxt;
  logic [7:0]         raw_r, raw_nxt;
  logic [7:0]         black_r, black_nxt;
  logic [3:0]         total_r, total_nxt;
  logic signed [14:0] wsum_r, wsum_nxt;
  logic               done_tick;
  logic [2:0]         lbit;
  logic               dark_hit;

  // divider
  logic [14:0] q_r, q_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic [3:0]  iter_r, iter_nxt;
  logic [3:0]  trial;
  logic [14:0] mag;
  logic [12:0] err_mag;

  // output register
  logic               out_valid_r;
  logic               out_free;
  logic               accept;
  logic               need_div;
  logic               load_tick;
  logic               load_div;

  assign cw       = lssc_pkg::ucode_rom(pc_r);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !(cw.wait_in && out_free);
  assign accept   = in_valid && !in_stall;

  // one tick of the scan
  always_comb begin
    scanning_nxt = scanning_r;
    chan_nxt     = chan_r;
    settle_nxt   = settle_r;
    raw_nxt      = raw_r;
    black_nxt    = black_r;
    total_nxt    = total_r;
    wsum_nxt     = wsum_r;
    done_tick    = 1'b0;
    lbit         = reverse_order_r ? ~chan_r : chan_r;
    dark_hit     = (in_sensor_level == black_is_high_r);
    if (!scanning_r) begin
      if (in_start_req) begin
        scanning_nxt = 1'b1;
        chan_nxt     = '0;
        settle_nxt   = '0;
        raw_nxt      = '0;
        black_nxt    = '0;
        total_nxt    = '0;
        wsum_nxt     = '0;
      end
    end else if (settle_r < settle_ticks_r) begin
      settle_nxt = settle_r + 16'd1;
    end else begin
      if (in_sensor_level) begin
        raw_nxt[lbit] = 1'b1;
      end
      if (dark_hit) begin
        black_nxt[lbit] = 1'b1;
        total_nxt       = total_r + 4'd1;
        wsum_nxt        = wsum_r + lssc_pkg::bit_weight(lbit);
      end
      if (chan_r == lssc_pkg::LAST_CHANNEL) begin
        scanning_nxt = 1'b0;
        done_tick    = 1'b1;
      end else begin
        chan_nxt   = chan_r + 3'd1;
        settle_nxt = '0;
      end
    end
  end

  assign need_div  = done_tick && (total_nxt != 4'd0);
  assign load_tick = accept && !need_div;
  assign load_div  = cw.emit && out_free;

  // sequencing
  always_comb begin
    case (cw.cond)
      lssc_pkg::COND_NONE:        taken = 1'b0;
      lssc_pkg::COND_DIV_PENDING: taken = accept && need_div;
      lssc_pkg::COND_ITER_MORE:   taken = (iter_r != 4'd0);
      lssc_pkg::COND_OUT_FREE:    taken = out_free;
      default:                    taken = 1'b0;
    endcase
    if (taken) begin
      pc_nxt = cw.target;
    end else if (cw.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + lssc_pkg::pc_t'(1);
    end
  end

  // restoring divide of |wsum| by total, one quotient bit per step
  assign mag   = wsum_r[14] ? 15'(-wsum_r) : 15'(wsum_r);
  assign trial = {rem_r, q_r[14]};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    iter_nxt = iter_r;
    if (cw.div_init) begin
      q_nxt    = mag;
      rem_nxt  = '0;
      iter_nxt = lssc_pkg::DIV_LAST_ITER;
    end else if (cw.div_step) begin
      iter_nxt = iter_r - 4'd1;
      if (trial >= total_r) begin
        rem_nxt = 3'(trial - total_r);
        q_nxt   = {q_r[13:0], 1'b1};
      end else begin
        rem_nxt = trial[2:0];
        q_nxt   = {q_r[13:0], 1'b0};
      end
    end
  end

  assign err_mag = {1'b0, q_r[11:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_order_r <= 1'b0;
      black_is_high_r <= 1'b1;
      settle_ticks_r  <= lssc_pkg::SETTLE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lssc_pkg::REG_REVERSE_ORDER: reverse_order_r <= cfg_wdata[0];
        lssc_pkg::REG_BLACK_IS_HIGH: black_is_high_r <= cfg_wdata[0];
        lssc_pkg::REG_SETTLE_TICKS:  settle_ticks_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r       <= lssc_pkg::PC_FETCH;
      scanning_r <= 1'b0;
      chan_r     <= '0;
      settle_r   <= '0;
      raw_r      <= '0;
      black_r    <= '0;
      total_r    <= '0;
      wsum_r     <= '0;
    end else begin
      pc_r <= pc_nxt;
      if (accept) begin
        scanning_r <= scanning_nxt;
        chan_r     <= chan_nxt;
        settle_r   <= settle_nxt;
        raw_r      <= raw_nxt;
        black_r    <= black_nxt;
        total_r    <= total_nxt;
        wsum_r     <= wsum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    iter_r <= iter_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_tick || load_div) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_tick) begin
      out_mux_select  <= chan_nxt;
      out_busy_res    <= scanning_nxt;
      out_done_res    <= done_tick;
      out_level_map   <= done_tick ? raw_nxt : 8'd0;
      out_dark_map    <= done_tick ? black_nxt : 8'd0;
      out_dark_total  <= done_tick ? total_nxt : 4'd0;
      out_track_found <= 1'b0;
      out_line_error  <= '0;
    end else if (load_div) begin
      out_mux_select  <= chan_r;
      out_busy_res    <= scanning_r;
      out_done_res    <= 1'b1;
      out_level_map   <= raw_r;
      out_dark_map    <= black_r;
      out_dark_total  <= total_r;
      out_track_found <= 1'b1;
      out_line_error  <= wsum_r[14] ? -$signed(err_mag) : $signed(err_mag);
    end
  end

  assign out_valid = out_valid_r;

  a_no_take_off_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r != lssc_pkg::PC_FETCH |-> in_stall)
    else $error("input taken outside fetch step");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == lssc_pkg::PC_DIVSTEP |-> total_r != 4'd0)
    else $error("divide with zero black count");

  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == lssc_pkg::PC_FINISH |-> q_r <= 15'd3500)
    else $error("centroid magnitude out of range");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_res |-> !out_busy_res)
    else $error("done word marked busy");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output word pending after reset");

endmodule

/* bench/line_sensor_scan_centroid_check.sv */
`timescale 1ns / 100ps
// Scoreboard for line_sensor_scan_centroid: tracks config writes and accepted
// tick words, predicts each result word and compares it. Uses lssc_pkg.

module line_sensor_scan_centroid_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_start_req,
  input  logic               in_sensor_level,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         out_mux_select,
  input  logic               out_busy_res,
  input  logic               out_done_res,
  input  logic [7:0]         out_level_map,
  input  logic [7:0]         out_dark_map,
  input  logic [3:0]         out_dark_total,
  input  logic               out_track_found,
  input  logic signed [12:0] out_line_error,
  output int                 fail_count,
  output int                 outstanding,
  output int                 scans_seen,
  output int                 words_seen
);

  typedef struct packed {
    logic [2:0]         mux;
    logic               busy;
    logic               done;
    logic [7:0]         raw;
    logic [7:0]         dark;
    logic [3:0]         dark_n;
    logic               seen;
    logic signed [12:0] err;
  } scan_word_t;

  scan_word_t scan_q[$];

  // config shadow
  logic        rev_r;
  logic        bih_r;
  logic [15:0] settle_r;

  // sequencer shadow
  logic        scanning;
  logic [2:0]  chan;
  logic [15:0] settle_cnt;
  logic [7:0]  raw_acc;
  logic [7:0]  dark_acc;
  logic [3:0]  dark_cnt;
  int          pos_sum;

  int err_n   = 0;
  int scans_n = 0;
  int words_n = 0;

  assign fail_count = err_n;
  assign scans_seen = scans_n;
  assign words_seen = words_n;

  task automatic scan_tick(input logic start, input logic level, output scan_word_t w);
    logic [2:0] lbit;
    w = '0;
    if (!scanning) begin
      if (start) begin
        scanning   = 1'b1;
        chan       = 3'd0;
        settle_cnt = 16'd0;
        raw_acc    = 8'd0;
        dark_acc   = 8'd0;
        dark_cnt   = 4'd0;
        pos_sum    = 0;
      end
    end else if (settle_cnt < settle_r) begin
      settle_cnt = settle_cnt + 16'd1;
    end else begin
      lbit = rev_r ? 3'd7 - chan : chan;
      if (level) raw_acc[lbit] = 1'b1;
      if (level == bih_r) begin
        dark_acc[lbit] = 1'b1;
        dark_cnt       = dark_cnt + 4'd1;
        pos_sum        = pos_sum + 1000 * int'(lbit) - 3500;
      end
      if (chan == lssc_pkg::LAST_CHANNEL) begin
        scanning = 1'b0;
        w.done   = 1'b1;
        w.raw    = raw_acc;
        w.dark   = dark_acc;
        w.dark_n = dark_cnt;
        if (dark_cnt != 4'd0) begin
          w.seen = 1'b1;
          w.err  = 13'(pos_sum / int'(dark_cnt));
        end
      end else begin
        chan       = chan + 3'd1;
        settle_cnt = 16'd0;
      end
    end
    w.mux  = chan;
    w.busy = scanning;
  endtask

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_n++;
    end
  endfunction

  always @(posedge clk) begin
    scan_word_t due;
    scan_word_t nxt;
    if (!rst_n) begin
      rev_r      = 1'b0;
      bih_r      = 1'b1;
      settle_r   = lssc_pkg::SETTLE_RESET;
      scanning   = 1'b0;
      chan       = 3'd0;
      settle_cnt = 16'd0;
      raw_acc    = 8'd0;
      dark_acc   = 8'd0;
      dark_cnt   = 4'd0;
      pos_sum    = 0;
      scan_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        words_n++;
        if (scan_q.size() == 0) begin
          $error("result word with nothing expected");
          err_n++;
        end else begin
          due = scan_q.pop_front();
          check_field("mux_select", 32'(due.mux), 32'(out_mux_select));
          check_field("busy_res", 32'(due.busy), 32'(out_busy_res));
          check_field("done_res", 32'(due.done), 32'(out_done_res));
          check_field("level_map", 32'(due.raw), 32'(out_level_map));
          check_field("dark_map", 32'(due.dark), 32'(out_dark_map));
          check_field("dark_total", 32'(due.dark_n), 32'(out_dark_total));
          check_field("track_found", 32'(due.seen), 32'(out_track_found));
          check_field("line_error", 32'(due.err), 32'(out_line_error));
          if (due.done) scans_n++;
        end
      end
      if (in_valid && !in_stall) begin
        scan_tick(in_start_req, in_sensor_level, nxt);
        scan_q.push_back(nxt);
      end
      if (cfg_we) begin
        case (cfg_index)
          lssc_pkg::REG_REVERSE_ORDER: rev_r    = cfg_wdata[0];
          lssc_pkg::REG_BLACK_IS_HIGH: bih_r    = cfg_wdata[0];
          lssc_pkg::REG_SETTLE_TICKS:  settle_r = cfg_wdata;
          default: ;
        endcase
      end
    end
    outstanding <= scan_q.size();
  end

endmodule

/* bench/line_sensor_scan_centroid_tb.sv */
`timescale 1ns / 100ps
// Top of the line_sensor_scan_centroid bench: clock, reset, tick stimulus,
// config writes and receiver stalls. Depends on lssc_pkg and the checker.

module line_sensor_scan_centroid_tb;

  localparam logic [1:0] REG_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         RAND_WORDS  = 1500;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic               in_start_req;
  logic               in_sensor_level;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         out_mux_select;
  logic               out_busy_res;
  logic               out_done_res;
  logic [7:0]         out_level_map;
  logic [7:0]         out_dark_map;
  logic [3:0]         out_dark_total;
  logic               out_track_found;
  logic signed [12:0] out_line_error;

  int fail_count;
  int outstanding;
  int scans_seen;
  int words_seen;
  int sent_n  = 0;
  int cycle_n = 0;
  bit idle_on = 1'b1;
  bit long_hold = 1'b0;
  bit long_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  line_sensor_scan_centroid dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_req    (in_start_req),
    .in_sensor_level (in_sensor_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_mux_select  (out_mux_select),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_level_map   (out_level_map),
    .out_dark_map    (out_dark_map),
    .out_dark_total  (out_dark_total),
    .out_track_found (out_track_found),
    .out_line_error  (out_line_error)
  );

  line_sensor_scan_centroid_check scan_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_req    (in_start_req),
    .in_sensor_level (in_sensor_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_mux_select  (out_mux_select),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_level_map   (out_level_map),
    .out_dark_map    (out_dark_map),
    .out_dark_total  (out_dark_total),
    .out_track_found (out_track_found),
    .out_line_error  (out_line_error),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .scans_seen      (scans_seen),
    .words_seen      (words_seen)
  );

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: short random stalls, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold && !long_done) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        long_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic tick(input logic start, input logic level);
    in_valid        <= 1'b1;
    in_start_req    <= start;
    in_sensor_level <= level;
    do @(posedge clk); while (in_stall);
    sent_n++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // settle 0: start word, then one sampled word per channel
  task automatic scan_pattern(input logic [7:0] levels, input logic hold_start);
    tick(1'b1, levels[0]);
    for (int ch = 0; ch < 8; ch++) tick(hold_start, levels[ch]);
  endtask

  function automatic logic level_for(input int mode);
    case (mode)
      0:       return 1'b0;
      1:       return 1'b1;
      default: return 1'($urandom);
    endcase
  endfunction

  initial begin
    int settle;
    int mode;
    cfg_we          = 1'b0;
    cfg_index       = lssc_pkg::REG_REVERSE_ORDER;
    cfg_wdata       = 16'd0;
    in_valid        = 1'b0;
    in_start_req    = 1'b0;
    in_sensor_level = 1'b0;
    rst_n           = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // one full scan at reset settings, receiver held off early on
    long_hold = 1'b1;
    tick(1'b1, 1'($urandom));
    repeat (8 * (int'(lssc_pkg::SETTLE_RESET) + 1)) tick(1'($urandom), 1'($urandom));
    drain();

    // directed scans
    write_reg(lssc_pkg::REG_SETTLE_TICKS, 16'h0000);
    write_reg(lssc_pkg::REG_REVERSE_ORDER, 16'hFFFE);
    scan_pattern(8'hFF, 1'b0);
    scan_pattern(8'h13, 1'b1);
    drain();
    write_reg(lssc_pkg::REG_REVERSE_ORDER, 16'hFFFF);
    write_reg(lssc_pkg::REG_BLACK_IS_HIGH, 16'hFFFE);
    scan_pattern(8'hFE, 1'b0);
    drain();
    write_reg(lssc_pkg::REG_REVERSE_ORDER, 16'h0000);
    write_reg(lssc_pkg::REG_BLACK_IS_HIGH, 16'h0001);
    write_reg(REG_SPARE, 16'hFFFF);
    scan_pattern(8'h00, 1'b0);
    drain();

    // longest settle, then cut short mid-wait
    write_reg(lssc_pkg::REG_SETTLE_TICKS, 16'hFFFF);
    tick(1'b1, 1'b1);
    repeat (150) tick(1'($urandom), 1'($urandom));
    drain();
    write_reg(lssc_pkg::REG_SETTLE_TICKS, 16'h0000);

    // random scans
    while (sent_n < RAND_WORDS) begin
      drain();
      idle_on = (sent_n < RAND_WORDS * 4 / 5) ? ($urandom_range(0, 3) != 0) : 1'b0;
      write_reg(lssc_pkg::REG_REVERSE_ORDER, 16'($urandom));
      write_reg(lssc_pkg::REG_BLACK_IS_HIGH, 16'($urandom));
      settle = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      write_reg(lssc_pkg::REG_SETTLE_TICKS, 16'(settle));
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, 16'($urandom));
      mode = $urandom_range(0, 3);
      tick(1'b1, level_for(mode));
      repeat (8 * (settle + 1) + $urandom_range(0, 2))
        tick($urandom_range(0, 5) == 0, level_for(mode));
      repeat ($urandom_range(0, 2)) tick(1'b0, 1'($urandom));
    end

    idle_on = 1'b0;
    drain();
    repeat (24) @(posedge clk);
    $display("Checked %0d result words including %0d finished scans", words_seen, scans_seen);
    $display("Settle times 0..12, 70 and 65535; both channel orders and level polarities");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lssc_pkg.sv
hw/rtl/line_sensor_scan_centroid.sv
bench/line_sensor_scan_centroid_check.sv
bench/line_sensor_scan_centroid_tb.sv
